### hw/rtl/pafc_pkg.sv
// ----------------------------------------------------------------------------
// pafc_pkg
// Shared types and constants of the partition allocator.
// ----------------------------------------------------------------------------
package pafc_pkg;
    localparam int MEMORY_UNITS   = 1024;
    localparam int MAX_PARTITIONS = 16;
    localparam int AW             = 11;
    localparam int OW             = 8;
    localparam int CW             = $clog2(MAX_PARTITIONS + 1);
    localparam int IW             = $clog2(MAX_PARTITIONS);

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NO_FIT     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND  = 2'd2;
    localparam logic [1:0] ST_TABLE_FULL = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic [AW-1:0] start;
        logic [AW-1:0] size;
        logic          busy;
        logic [OW-1:0] owner;
    } entry_t;

    // commands from the sequencer to every cell of the row
    localparam logic [1:0] CMD_HOLD  = 2'd0;
    localparam logic [1:0] CMD_SHUP  = 2'd1; // take left neighbor's entry
    localparam logic [1:0] CMD_SHDN  = 2'd2; // take right neighbor's entry
    localparam logic [1:0] CMD_WRITE = 2'd3;

    typedef struct packed {
        logic [1:0]    cmd;
        logic [IW-1:0] pos;     // shifts move cells above pos (down also pos)
        logic [IW-1:0] wr_idx;
        entry_t        wr_data;
    } row_ctl_t;
endpackage

### hw/rtl/pafc_cell.sv
// ----------------------------------------------------------------------------
// pafc_cell
// One table entry; shifts to or from its neighbors or takes a write.
// ----------------------------------------------------------------------------
module pafc_cell
    import pafc_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [IW-1:0] my_idx,
    input  entry_t        rst_val,
    input  row_ctl_t      ctl,
    input  entry_t        left_in,
    input  entry_t        right_in,
    output entry_t        q
);
    entry_t ent_reg, ent_next;

    always_comb begin
        ent_next = ent_reg;
        case (ctl.cmd)
            CMD_SHUP:  if (my_idx > ctl.pos) ent_next = left_in;
            CMD_SHDN:  if (my_idx >= ctl.pos) ent_next = right_in;
            CMD_WRITE: if (my_idx == ctl.wr_idx) ent_next = ctl.wr_data;
            default:   ent_next = ent_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_reg <= rst_val;
        end else begin
            ent_reg <= ent_next;
        end
    end

    assign q = ent_reg;
endmodule

### hw/rtl/partition_allocator_fit_coalesce_core.sv
// ----------------------------------------------------------------------------
// partition_allocator_fit_coalesce_core
// Variable-partition allocator, first/best fit, coalescing on free.
// ----------------------------------------------------------------------------
// One request at a time. The table is a row of sixteen cells; a sequencer scans
// them one entry per cycle, then edits the row with whole-row shift and write
// steps (at most four). The result sits in an output register and the next
// request is taken once it has been delivered.
module partition_allocator_fit_coalesce_core
    import pafc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // opcode, owner_id[8], request_size[11], pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // status[2], start[11], area_size[11],
                                   // partition_count[5], pad
);
    localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_ED1 = 3'd2,
                           S_ED2 = 3'd3, S_ED3 = 3'd4, S_OUT = 3'd5,
                           S_ED4 = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic          pol_reg;
    logic          op_reg;
    logic [OW-1:0] own_reg;
    logic [AW-1:0] req_reg;
    logic [CW-1:0] used_reg, used_next;
    logic [CW-1:0] i_reg;
    logic          fnd_reg;
    logic [IW-1:0] pick_reg;
    logic [AW-1:0] best_reg;
    logic [1:0]    st_reg;
    logic [AW-1:0] ad_reg, sz_reg;
    logic          mb_reg;   // merged with right neighbor

    entry_t   q [MAX_PARTITIONS];
    row_ctl_t ctl;
    entry_t   zero_e, init_e;

    assign zero_e = '0;
    assign init_e = '{start: AW'(1), size: AW'(MEMORY_UNITS), busy: 1'b0, owner: '0};

    for (genvar g = 0; g < MAX_PARTITIONS; g++) begin : g_row
        entry_t lft, rgt;
        if (g == 0) begin : g_l
            assign lft = zero_e;
        end else begin : g_l
            assign lft = q[g-1];
        end
        if (g == MAX_PARTITIONS - 1) begin : g_r
            assign rgt = zero_e;
        end else begin : g_r
            assign rgt = q[g+1];
        end
        pafc_cell u_cell (
            .aclk(aclk), .aresetn(aresetn), .my_idx(IW'(g)),
            .rst_val((g == 0) ? init_e : zero_e), .ctl(ctl),
            .left_in(lft), .right_in(rgt), .q(q[g])
        );
    end

    entry_t        e_i, e_p, e_pn, e_pp;
    logic [IW-1:0] ii, pn, pp;
    logic          cand, scan_done;
    logic          merge_r, ed1_fail;
    assign ii   = i_reg[IW-1:0];
    assign pn   = pick_reg + IW'(1);
    assign pp   = pick_reg - IW'(1);
    assign e_i  = q[ii];
    assign e_p  = q[pick_reg];
    assign e_pn = q[pn];
    assign e_pp = q[pp];
    assign cand = (op_reg == OP_ALLOC) ? (!e_i.busy && e_i.size >= req_reg)
                                       : (e_i.busy && e_i.owner == own_reg);
    // right neighbor inside the table and free
    assign merge_r = CW'(pn) < used_reg &&
                     {1'b0, pick_reg} != CW'(MAX_PARTITIONS - 1) && !e_pn.busy;
    assign ed1_fail = (op_reg == OP_ALLOC) ?
                      (!fnd_reg || req_reg == '0 ||
                       (e_p.size != req_reg && used_reg >= CW'(MAX_PARTITIONS))) :
                      !fnd_reg;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {3'b0, used_reg, sz_reg, ad_reg, st_reg};

    always_comb begin
        state_next = state_reg;
        used_next  = used_reg;
        ctl        = '0;
        ctl.cmd    = CMD_HOLD;
        scan_done  = 1'b0;
        case (state_reg)
            S_IDLE: if (s_tvalid) state_next = S_SCAN;
            S_SCAN: begin
                if (i_reg >= used_reg ||
                    (cand && (op_reg == OP_FREE || !pol_reg))) begin
                    state_next = S_ED1;
                    scan_done  = 1'b1;
                end
            end
            S_ED1: begin
                state_next = S_OUT;
                if (op_reg == OP_ALLOC && fnd_reg && req_reg != '0) begin
                    if (e_p.size == req_reg) begin
                        ctl.cmd     = CMD_WRITE;
                        ctl.wr_idx  = pick_reg;
                        ctl.wr_data = '{start: e_p.start, size: req_reg,
                                        busy: 1'b1, owner: own_reg};
                    end else if (used_reg < CW'(MAX_PARTITIONS)) begin
                        ctl.cmd   = CMD_SHUP;
                        ctl.pos   = pick_reg;
                        used_next = used_reg + CW'(1);
                        state_next = S_ED2;
                    end
                end else if (op_reg == OP_FREE && fnd_reg) begin
                    ctl.cmd     = CMD_WRITE;
                    ctl.wr_idx  = pick_reg;
                    ctl.wr_data = '{start: e_p.start, size: e_p.size,
                                    busy: 1'b0, owner: '0};
                    if (merge_r)
                        ctl.wr_data.size = e_p.size + e_pn.size;
                    state_next = S_ED2;
                end
            end
            S_ED2: begin
                if (op_reg == OP_ALLOC) begin
                    // cell pick+1 now holds the free remainder
                    ctl.cmd     = CMD_WRITE;
                    ctl.wr_idx  = pn;
                    ctl.wr_data = '{start: e_pn.start + req_reg,
                                    size: e_pn.size - req_reg, busy: 1'b0, owner: '0};
                    state_next  = S_ED3;
                end else if (mb_reg) begin
                    ctl.cmd   = CMD_SHDN;
                    ctl.pos   = pn;
                    used_next = used_reg - CW'(1);
                    state_next = S_ED3;
                end else begin
                    state_next = S_ED3;
                end
            end
            S_ED3: begin
                state_next = S_OUT;
                if (op_reg == OP_ALLOC) begin
                    ctl.cmd     = CMD_WRITE;
                    ctl.wr_idx  = pick_reg;
                    ctl.wr_data = '{start: e_p.start, size: req_reg,
                                    busy: 1'b1, owner: own_reg};
                end else if (pick_reg != '0 && !e_pp.busy) begin
                    // cell pick holds the freed entry after any right merge
                    ctl.cmd     = CMD_WRITE;
                    ctl.wr_idx  = pp;
                    ctl.wr_data = '{start: e_pp.start, size: e_pp.size + e_p.size,
                                    busy: 1'b0, owner: '0};
                    state_next  = S_ED4;
                end
            end
            // left merge needs a shift after its write
            S_ED4: begin
                ctl.cmd    = CMD_SHDN;
                ctl.pos    = pick_reg;
                used_next  = used_reg - CW'(1);
                state_next = S_OUT;
            end
            S_OUT: begin
                if (m_tready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            pol_reg   <= 1'b1;
            used_reg  <= CW'(1);
        end else begin
            state_reg <= state_next;
            used_reg  <= used_next;
            if (cfg_we) pol_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                op_reg  <= s_tdata[0];
                own_reg <= s_tdata[8:1];
                req_reg <= s_tdata[19:9];
                i_reg   <= '0;
                fnd_reg <= 1'b0;
            end
            S_SCAN: begin
                if (!scan_done) i_reg <= i_reg + CW'(1);
                if (i_reg < used_reg && cand &&
                    (!fnd_reg || op_reg == OP_FREE || (e_i.size - req_reg) < best_reg)) begin
                    fnd_reg  <= 1'b1;
                    pick_reg <= ii;
                    best_reg <= e_i.size - req_reg;
                end
                st_reg <= ST_OK;
            end
            S_ED1: begin
                ad_reg <= ed1_fail ? '0 : e_p.start;
                if (op_reg == OP_ALLOC) begin
                    sz_reg <= ed1_fail ? '0 : req_reg;
                    mb_reg <= 1'b0;
                    if (!fnd_reg || req_reg == '0) st_reg <= ST_NO_FIT;
                    else if (e_p.size != req_reg && used_reg >= CW'(MAX_PARTITIONS))
                        st_reg <= ST_TABLE_FULL;
                end else begin
                    sz_reg <= ed1_fail ? '0 : e_p.size;
                    mb_reg <= merge_r;
                    if (!fnd_reg) st_reg <= ST_NOT_FOUND;
                end
            end
            default: ;
        endcase
    end
endmodule

### hw/rtl/pafc_checker.sv
// ----------------------------------------------------------------------------
// pafc_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module pafc_checker
    import pafc_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);
    // one request in flight: never ready while a result waits
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("ready with result pending");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped");
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[28:24] != 5'd0 && m_tdata[28:24] <= 5'd16)
        else $error("bad count");
    a_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] != ST_OK |-> m_tdata[23:2] == 22'd0)
        else $error("failure carries data");
endmodule

bind partition_allocator_fit_coalesce_core pafc_checker u_pafc_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

### bench/alloc_checker.sv
// ----------------------------------------------------------------------------
// alloc_checker
// Watches the request and result streams of the partition allocator, keeps
// its own partition table, predicts each result and compares field by field.
// ----------------------------------------------------------------------------
module alloc_checker
    import pafc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    output int          fail_count,
    output int          pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]    status;
        logic [AW-1:0] addr;
        logic [AW-1:0] size;
        logic [4:0]    count;
    } alloc_result_t;

    entry_t        table_q[$];
    logic          best_fit;
    alloc_result_t result_q[$];

    assign pending_results = result_q.size();

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    function automatic alloc_result_t predict_alloc(input logic [7:0] owner,
                                                    input logic [10:0] req);
        alloc_result_t r;
        int pick;
        int best;
        entry_t e;
        r = '0;
        pick = -1;
        best = 0;
        if (req != 0) begin
            foreach (table_q[i]) begin
                if (table_q[i].busy || table_q[i].size < req) continue;
                if (!best_fit) begin
                    pick = i;
                    break;
                end
                if (pick < 0 || table_q[i].size - req < best) begin
                    pick = i;
                    best = table_q[i].size - req;
                end
            end
        end
        if (pick < 0) begin
            r.status = ST_NO_FIT;
        end else if (table_q[pick].size == req) begin
            table_q[pick].busy = 1'b1;
            table_q[pick].owner = owner;
            r.status = ST_OK;
            r.addr = table_q[pick].start;
            r.size = req;
        end else if (table_q.size() >= MAX_PARTITIONS) begin
            r.status = ST_TABLE_FULL;
        end else begin
            e.start = table_q[pick].start;
            e.size = req;
            e.busy = 1'b1;
            e.owner = owner;
            table_q[pick].start = table_q[pick].start + req;
            table_q[pick].size = table_q[pick].size - req;
            table_q.insert(pick, e);
            r.status = ST_OK;
            r.addr = e.start;
            r.size = req;
        end
        r.count = 5'(table_q.size());
        return r;
    endfunction

    function automatic alloc_result_t predict_free(input logic [7:0] owner);
        alloc_result_t r;
        int hit;
        r = '0;
        hit = -1;
        foreach (table_q[i]) begin
            if (table_q[i].busy && table_q[i].owner == owner) begin
                hit = i;
                break;
            end
        end
        if (hit < 0) begin
            r.status = ST_NOT_FOUND;
        end else begin
            r.status = ST_OK;
            r.addr = table_q[hit].start;
            r.size = table_q[hit].size;
            table_q[hit].busy = 1'b0;
            table_q[hit].owner = '0;
            if (hit + 1 < table_q.size() && !table_q[hit+1].busy) begin
                table_q[hit].size = table_q[hit].size + table_q[hit+1].size;
                table_q.delete(hit + 1);
            end
            if (hit > 0 && !table_q[hit-1].busy) begin
                table_q[hit-1].size = table_q[hit-1].size + table_q[hit].size;
                table_q.delete(hit);
            end
        end
        r.count = 5'(table_q.size());
        return r;
    endfunction

    always @(posedge aclk) begin
        alloc_result_t want;
        alloc_result_t got;
        entry_t first;
        if (!aresetn) begin
            fail_count = 0;
            first.start = 11'd1;
            first.size = AW'(MEMORY_UNITS);
            first.busy = 1'b0;
            first.owner = '0;
            table_q = '{first};
            best_fit = 1'b1;
            result_q = {};
        end else begin
            if (cfg_we) best_fit = cfg_wdata;
            if (s_tvalid && s_tready) begin
                if (s_tdata[0] == OP_ALLOC)
                    result_q.push_back(predict_alloc(s_tdata[8:1], s_tdata[19:9]));
                else
                    result_q.push_back(predict_free(s_tdata[8:1]));
            end
            if (m_tvalid && m_tready) begin
                got.status = m_tdata[1:0];
                got.addr = m_tdata[12:2];
                got.size = m_tdata[23:13];
                got.count = m_tdata[28:24];
                if (result_q.size() == 0) begin
                    report_mismatch("unexpected result", m_tdata, 0);
                end else begin
                    want = result_q[0];
                    result_q.delete(0);
                    if (got.status != want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.addr != want.addr)
                        report_mismatch("start", got.addr, want.addr);
                    if (got.size != want.size)
                        report_mismatch("area_size", got.size, want.size);
                    if (got.count != want.count)
                        report_mismatch("partition_count", got.count, want.count);
                end
            end
        end
    end
endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives allocate and free requests into the partition allocator in bursts,
// with a stalling result side, under both fit policies, and gives the verdict.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pafc_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic        cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    int          fail_count;
    int          pending_results;
    int          cycle_count;
    int          gap_left;
    int          burst_left;

    partition_allocator_fit_coalesce_core DUT (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    alloc_checker u_checker (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending_results(pending_results)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // receiver stall pattern, with quiet stretches of no stalling
    initial begin
        int mode;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > 400000) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // one request; bursts of back-to-back requests separated by random gaps
    task automatic send_request(input logic op, input logic [7:0] owner,
                                input logic [10:0] req);
        if (burst_left == 0) begin
            gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 30);
            burst_left = $urandom_range(1, 12);
            if (gap_left > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap_left) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'd0, req, owner, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
    endtask

    task automatic drain_results;
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_results != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task automatic write_policy(input logic best);
        drain_results();
        cfg_we <= 1'b1;
        cfg_wdata <= best;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // mostly owners from a small pool so that frees find their partitions
    task automatic random_phase(input int n);
        logic [7:0]  owner;
        logic [10:0] req;
        int          r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            owner = r < 85 ? 8'($urandom_range(1, 20)) : 8'($urandom);
            if (r < 50) req = 11'($urandom_range(1, 64));
            else if (r < 80) req = 11'($urandom_range(1, 300));
            else if (r < 90) req = 11'($urandom_range(0, 1024));
            else req = 11'($urandom);
            send_request($urandom_range(0, 99) < 55 ? OP_ALLOC : OP_FREE, owner, req);
            if (i == n / 2) drain_results();
        end
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        burst_left = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: zero size, oversize, exact fit of whole memory, owner zero
        send_request(OP_ALLOC, 8'd1, 11'd0);
        send_request(OP_ALLOC, 8'd1, 11'd1025);
        send_request(OP_ALLOC, 8'd1, 11'h7FF);
        send_request(OP_ALLOC, 8'd0, 11'd1024);
        send_request(OP_FREE, 8'd7, 11'h7FF);
        send_request(OP_FREE, 8'd0, 11'd0);
        // fill the table with splits until it is full
        for (int i = 1; i <= 16; i++) send_request(OP_ALLOC, 8'(i), 11'd10);
        send_request(OP_FREE, 8'd255, 11'd0);
        send_request(OP_FREE, 8'd3, 11'd0);
        send_request(OP_FREE, 8'd1, 11'd0);
        send_request(OP_FREE, 8'd2, 11'd0);

        write_policy(1'b0);
        send_request(OP_ALLOC, 8'd200, 11'd5);
        send_request(OP_ALLOC, 8'd201, 11'd25);
        random_phase(600);
        write_policy(1'b1);
        random_phase(650);
        write_policy(1'b0);
        random_phase(620);

        drain_results();
        if (fail_count == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end
endmodule
